### hdl/pcm_pkg.sv
// Package for the PWM capture measurement block.
// Holds the divider widths, scale constants, iteration counts and shared types.
// No dependencies.
package pcm_pkg;

  localparam int TIMESTAMP_WIDTH_DEF = 32;
  localparam int TIME_WIDTH          = 32;
  localparam int RATE_WIDTH          = 28;
  localparam int FREQ_WIDTH          = 34;
  localparam int DUTY_WIDTH          = 14;
  localparam int PULSE_WIDTH         = 32;

  localparam logic [RATE_WIDTH-1:0] TICK_RATE_RESET = RATE_WIDTH'(10000000);

  localparam int DIV_WIDTH = 54;
  localparam int REM_WIDTH = 32;
  localparam int CNT_WIDTH = 6;
  localparam int MUL_A_WIDTH = 32;
  localparam int MUL_K_WIDTH = 20;
  localparam int MUL_P_WIDTH = MUL_A_WIDTH + MUL_K_WIDTH;

  localparam logic [MUL_K_WIDTH-1:0] FREQ_SCALE = MUL_K_WIDTH'(100);
  localparam logic [MUL_K_WIDTH-1:0] DUTY_FULL  = MUL_K_WIDTH'(10000);
  localparam logic [MUL_K_WIDTH-1:0] US_PER_S   = MUL_K_WIDTH'(1000000);

  localparam int FREQ_ITER  = 35;
  localparam int DUTY_ITER  = 46;
  localparam int PULSE_ITER = 52;
  localparam int FREQ_SHIFT  = DIV_WIDTH - FREQ_ITER;
  localparam int DUTY_SHIFT  = DIV_WIDTH - DUTY_ITER;
  localparam int PULSE_SHIFT = DIV_WIDTH - PULSE_ITER;

  typedef struct packed {
    logic                 start;
    logic [CNT_WIDTH-1:0] count;
  } pcm_div_ctrl_t;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_START = 5'b00010,
    S_FREQ  = 5'b00100,
    S_DUTY  = 5'b01000,
    S_PULSE = 5'b10000
  } pcm_state_t;

endpackage

### hdl/pcm_divider.sv
// Shared restoring divider, one quotient bit per clock cycle.
// The dividend arrives left-aligned so that the quotient ends in the low bits.
// Depends on pcm_pkg.
module pcm_divider
  import pcm_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  pcm_div_ctrl_t        ctrl,
  input  logic [DIV_WIDTH-1:0] dividend,
  input  logic [REM_WIDTH-1:0] divisor,
  output logic                 done,
  output logic [DIV_WIDTH-1:0] quotient,
  output logic [REM_WIDTH-1:0] remainder
);

  logic [DIV_WIDTH-1:0] quo;
  logic [REM_WIDTH-1:0] rem;
  logic [REM_WIDTH-1:0] den;
  logic [CNT_WIDTH-1:0] count;
  logic                 busy;

  logic [REM_WIDTH+1:0] trial;
  logic                 fits;
  logic [REM_WIDTH-1:0] rem_next;
  logic [DIV_WIDTH-1:0] quo_next;

  always_comb begin
    trial    = {1'b0, rem, quo[DIV_WIDTH-1]} - {2'b00, den};
    fits     = !trial[REM_WIDTH+1];
    rem_next = fits ? trial[REM_WIDTH-1:0] : {rem[REM_WIDTH-2:0], quo[DIV_WIDTH-1]};
    quo_next = {quo[DIV_WIDTH-2:0], fits};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (ctrl.start) begin
        busy  <= 1'b1;
        count <= ctrl.count;
        quo   <= dividend;
        rem   <= '0;
        den   <= divisor;
      end else if (busy) begin
        quo   <= quo_next;
        rem   <= rem_next;
        count <= count - CNT_WIDTH'(1);
        if (count == CNT_WIDTH'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quotient  = quo;
  assign remainder = rem;

endmodule

### hdl/pwm_capture_measure.sv
// Top level of the PWM capture measurement block: edge sequencer, state,
// configuration register, shared constant multiplier and output register.
// Depends on pcm_pkg and pcm_divider.
//
// Usage: the input channel carries one capture timestamp (mode 0) or a restart
// (mode 1) per transfer; edges are expected as rise, fall, rise. Every input
// transfer gives exactly one output transfer. The output channel holds its
// result in a register until the receiver takes it; while the receiver stalls,
// the result and its fields stay unchanged.
// Restarts, first rises and falls produce their result in the cycle after the
// transfer. A closing rise runs three divisions on one shared serial divider
// (35, 46 and 52 iterations, one quotient bit per cycle); the input stalls
// until its result is registered.
// A new input transfer is taken whenever the block is idle and the output
// register is empty or being emptied in the same cycle.
// The user must write the tick rate register through cfg_we and cfg_data
// only while idle; the block does not enforce this. Reset (synchronous) sets
// the tick rate to 10 MHz, empties the output and waits for a rising edge.
module pwm_capture_measure
  import pcm_pkg::*;
#(
  parameter int TIMESTAMP_WIDTH = TIMESTAMP_WIDTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [RATE_WIDTH-1:0]  cfg_data,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic                   mode,
  input  logic [TIME_WIDTH-1:0]  capture_time,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic                   next_edge_falling,
  output logic                   measure_valid,
  output logic [TIME_WIDTH-1:0]  period_count,
  output logic [TIME_WIDTH-1:0]  high_count,
  output logic [FREQ_WIDTH-1:0]  frequency_centihz,
  output logic [DUTY_WIDTH-1:0]  duty_centipercent,
  output logic [PULSE_WIDTH-1:0] pulse_width_us
);

  localparam logic [TIME_WIDTH-1:0] TS_MASK =
    TIME_WIDTH'((64'd1 << TIMESTAMP_WIDTH) - 64'd1);

  pcm_state_t            state;
  logic [1:0]            phase;
  logic [TIME_WIDTH-1:0] first_rise_time;
  logic [TIME_WIDTH-1:0] high_time;
  logic [RATE_WIDTH-1:0] tick_rate;

  logic                  accept;
  logic                  out_free;
  logic [TIME_WIDTH-1:0] cap_masked;
  logic [TIME_WIDTH-1:0] diff;
  logic [1:0]            phase_next;
  logic                  closing;

  pcm_div_ctrl_t         div_ctrl;
  logic [DIV_WIDTH-1:0]  div_dividend;
  logic [REM_WIDTH-1:0]  div_divisor;
  logic                  div_done;
  logic [DIV_WIDTH-1:0]  div_quotient;
  logic [REM_WIDTH-1:0]  div_remainder;

  logic [MUL_A_WIDTH-1:0] mul_a;
  logic [MUL_K_WIDTH-1:0] mul_k;
  logic [MUL_P_WIDTH-1:0] product;

  logic [FREQ_WIDTH-1:0]  freq_val;
  logic [DUTY_WIDTH-1:0]  duty_val;
  logic                   round_up;
  logic [DIV_WIDTH:0]     pulse_sum;
  logic [PULSE_WIDTH-1:0] pulse_val;

  assign out_free   = !out_valid || !out_stall;
  assign in_stall   = (state != S_IDLE) || !out_free;
  assign accept     = in_valid && !in_stall;
  assign cap_masked = capture_time & TS_MASK;
  assign diff       = (cap_masked - first_rise_time) & TS_MASK;
  assign product    = MUL_P_WIDTH'(mul_a) * MUL_P_WIDTH'(mul_k);

  always_comb begin
    phase_next = 2'd0;
    closing    = 1'b0;
    if (!mode) begin
      case (phase)
        2'd0: begin
          phase_next = 2'd1;
        end
        2'd1: begin
          phase_next = 2'd2;
        end
        2'd2: begin
          phase_next = 2'd1;
          closing    = 1'b1;
        end
        default: begin
          phase_next = 2'd0;
        end
      endcase
    end
  end

  always_comb begin
    div_ctrl.start = 1'b0;
    div_ctrl.count = '0;
    mul_a          = '0;
    mul_k          = '0;
    div_dividend   = '0;
    div_divisor    = '0;
    case (state)
      S_START: begin
        div_ctrl.start = 1'b1;
        div_ctrl.count = CNT_WIDTH'(FREQ_ITER);
        mul_a          = MUL_A_WIDTH'(tick_rate);
        mul_k          = FREQ_SCALE;
        div_dividend   = DIV_WIDTH'(product) << FREQ_SHIFT;
        div_divisor    = period_count;
      end
      S_FREQ: begin
        div_ctrl.start = div_done;
        div_ctrl.count = CNT_WIDTH'(DUTY_ITER);
        mul_a          = high_count;
        mul_k          = DUTY_FULL;
        div_dividend   = DIV_WIDTH'(product) << DUTY_SHIFT;
        div_divisor    = period_count;
      end
      S_DUTY: begin
        div_ctrl.start = div_done;
        div_ctrl.count = CNT_WIDTH'(PULSE_ITER);
        mul_a          = high_count;
        mul_k          = US_PER_S;
        div_dividend   = DIV_WIDTH'(product) << PULSE_SHIFT;
        div_divisor    = REM_WIDTH'(tick_rate);
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    if (period_count == '0) begin
      freq_val = '0;
      duty_val = '0;
    end else begin
      freq_val = div_quotient[FREQ_WIDTH] ? {FREQ_WIDTH{1'b1}}
                                          : div_quotient[FREQ_WIDTH-1:0];
      duty_val = (div_quotient > DIV_WIDTH'(DUTY_FULL)) ? DUTY_WIDTH'(DUTY_FULL)
                                                        : div_quotient[DUTY_WIDTH-1:0];
    end
    round_up  = {div_remainder, 1'b0} >= (REM_WIDTH + 1)'(tick_rate);
    pulse_sum = (DIV_WIDTH + 1)'(div_quotient) + (DIV_WIDTH + 1)'(round_up);
    if (tick_rate == '0 || pulse_sum[DIV_WIDTH:PULSE_WIDTH] != '0) begin
      pulse_val = {PULSE_WIDTH{1'b1}};
    end else begin
      pulse_val = pulse_sum[PULSE_WIDTH-1:0];
    end
  end

  pcm_divider u_divider (
    .clk       (clk),
    .rst       (rst),
    .ctrl      (div_ctrl),
    .dividend  (div_dividend),
    .divisor   (div_divisor),
    .done      (div_done),
    .quotient  (div_quotient),
    .remainder (div_remainder)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_rate <= TICK_RATE_RESET;
    end else if (cfg_we) begin
      tick_rate <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      phase           <= 2'd0;
      first_rise_time <= '0;
      high_time       <= '0;
      out_valid       <= 1'b0;
    end else begin
      if (state == S_PULSE && div_done) begin
        out_valid <= 1'b1;
      end else if (accept) begin
        out_valid <= !closing;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      if (accept) begin
        phase             <= phase_next;
        next_edge_falling <= (phase_next == 2'd1);
        measure_valid     <= closing;
        period_count      <= closing ? diff : '0;
        high_count        <= closing ? high_time : '0;
        if (!mode && (phase == 2'd0 || phase == 2'd2)) begin
          first_rise_time <= cap_masked;
        end
        if (!mode && phase == 2'd1) begin
          high_time <= diff;
        end
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            frequency_centihz <= '0;
            duty_centipercent <= '0;
            pulse_width_us    <= '0;
            if (closing) begin
              state <= S_START;
            end
          end
        end
        S_START: begin
          state <= S_FREQ;
        end
        S_FREQ: begin
          if (div_done) begin
            frequency_centihz <= freq_val;
            state             <= S_DUTY;
          end
        end
        S_DUTY: begin
          if (div_done) begin
            duty_centipercent <= duty_val;
            state             <= S_PULSE;
          end
        end
        S_PULSE: begin
          if (div_done) begin
            pulse_width_us <= pulse_val;
            state          <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
